// ----- hw/rtl/eth_ipv4_tcp_header_parser_unit_defines.svh -----
// assertion macros used by the checker file
`ifndef ETH_IPV4_TCP_HEADER_PARSER_UNIT_DEFINES_SVH
`define ETH_IPV4_TCP_HEADER_PARSER_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define EITP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("eitp assertion failed");

// next-cycle implication, off during reset
`define EITP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("eitp assertion failed");

`endif

// ----- hw/rtl/eitp_pkg.sv -----
package eitp_pkg;

  localparam int EthHdrLen   = 14;
  localparam int IpMinLen    = 20;
  localparam int TcpMinLen   = 20;
  localparam int WordBytes   = 4;
  localparam int TcpFlagsOff = 13;

  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [15:0] EtherTypeArp  = 16'h0806;
  localparam logic [7:0]  ProtoTcp      = 8'd6;
  localparam logic [7:0]  ProtoUdp      = 8'd17;
  localparam logic [7:0]  ProtoIcmp     = 8'd1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT_ETH = 3'd1,
    ST_SHORT_IP  = 3'd2,
    ST_BAD_IHL   = 3'd3,
    ST_SHORT_TCP = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PKT_UNKNOWN = 2'd0,
    PKT_IPV4    = 2'd1,
    PKT_ARP     = 2'd2
  } pkt_e;

  typedef enum logic [1:0] {
    TR_UNKNOWN = 2'd0,
    TR_TCP     = 2'd1,
    TR_UDP     = 2'd2,
    TR_ICMP    = 2'd3
  } trans_e;

  // per-frame decode state
  typedef struct packed {
    logic [15:0] offset;
    logic [15:0] ether_kind;
    logic [3:0]  header_words;
    logic [7:0]  proto;
    logic [15:0] length;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [4:0]  flags;
  } frame_t;

  localparam frame_t FrameReset = '{
    offset:       16'd0,
    ether_kind:   16'd0,
    header_words: 4'd0,
    proto:        8'd0,
    length:       16'd0,
    src_addr:     32'd0,
    dst_addr:     32'd0,
    src_port:     16'hFFFF,
    dst_port:     16'hFFFF,
    flags:        5'd0
  };

  // one summary word
  typedef struct packed {
    status_e     status;
    pkt_e        packet_type;
    trans_e      transport_type;
    logic [15:0] total_length;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [4:0]  tcp_flag_bits;
  } summary_t;

endpackage

// ----- hw/rtl/eth_ipv4_tcp_header_parser_unit.sv -----
// channel | signals                               | dir | word
// --------+---------------------------------------+-----+---------------------------
// in      | in_valid_i, in_stall_o                | in  | data_byte_i, last_i
// out     | out_valid_o, out_stall_i              | out | status_o .. tcp_flag_bits_o
//
// one byte a cycle sustained unless a last byte waits on a held summary; a last
// byte passes the input register, then its summary shows from the summary register
// the frame state update and the summary decode share the single stage between them
// bytes that are not last never wait on the output side; a last byte waits only
// while a summary is still held by out_stall_i
// rst_ni clears the frame state and both valid flags; no clearing pass is needed
module eth_ipv4_tcp_header_parser_unit import eitp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [1:0]  packet_type_o,
  output logic [1:0]  transport_type_o,
  output logic [15:0] total_length_o,
  output logic [31:0] source_address_o,
  output logic [31:0] dest_address_o,
  output logic [15:0] source_port_o,
  output logic [15:0] dest_port_o,
  output logic [4:0]  tcp_flag_bits_o
);

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic       in_take;

  // stage advance: a last byte needs room in the summary register
  logic       advance;

  // summary register
  logic       out_valid_q, out_valid_d;
  summary_t   sum_q;
  summary_t   sum_d;
  frame_t     cap;

  assign advance    = in_valid_q && (!last_q || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;
  assign in_valid_d = (in_valid_q && !advance) || in_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      byte_q <= data_byte_i;
      last_q <= last_i;
    end
  end

  // frame state, cleared after the last byte
  eitp_capture u_capture (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (byte_q),
    .last_i (last_q),
    .cap_o  (cap)
  );

  // status and field selection on the captured frame
  eitp_classify u_classify (
    .cap_i (cap),
    .sum_o (sum_d)
  );

  // a held summary drops once taken, a new one loads on a last byte
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (advance && last_q) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last_q) begin
      sum_q <= sum_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = sum_q.status;
  assign packet_type_o    = sum_q.packet_type;
  assign transport_type_o = sum_q.transport_type;
  assign total_length_o   = sum_q.total_length;
  assign source_address_o = sum_q.source_address;
  assign dest_address_o   = sum_q.dest_address;
  assign source_port_o    = sum_q.source_port;
  assign dest_port_o      = sum_q.dest_port;
  assign tcp_flag_bits_o  = sum_q.tcp_flag_bits;

endmodule

// ----- hw/rtl/eitp_capture.sv -----
module eitp_capture import eitp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output frame_t     cap_o
);

  frame_t      frame_q, frame_d;
  logic [6:0]  tcp_start;
  logic [15:0] tcp_rel;

  // fields with the current byte folded in, offset still that of the byte
  always_comb begin
    cap_o = frame_q;
    case (frame_q.offset)
      16'd12:  cap_o.ether_kind[15:8] = byte_i;
      16'd13:  cap_o.ether_kind[7:0]  = byte_i;
      16'd14:  cap_o.header_words     = byte_i[3:0];
      16'd16:  cap_o.length[15:8]     = byte_i;
      16'd17:  cap_o.length[7:0]      = byte_i;
      16'd23:  cap_o.proto            = byte_i;
      16'd26, 16'd27, 16'd28, 16'd29:
               cap_o.src_addr = {frame_q.src_addr[23:0], byte_i};
      16'd30, 16'd31, 16'd32, 16'd33:
               cap_o.dst_addr = {frame_q.dst_addr[23:0], byte_i};
      default: ;
    endcase

    // tcp header starts after the ip options
    tcp_start = 7'(EthHdrLen) + {1'b0, cap_o.header_words, 2'b00};
    tcp_rel   = frame_q.offset - {9'd0, tcp_start};
    if ((cap_o.header_words >= 4'(IpMinLen / WordBytes)) &&
        (frame_q.offset >= {9'd0, tcp_start})) begin
      case (tcp_rel)
        16'd0:   cap_o.src_port[15:8] = byte_i;
        16'd1:   cap_o.src_port[7:0]  = byte_i;
        16'd2:   cap_o.dst_port[15:8] = byte_i;
        16'd3:   cap_o.dst_port[7:0]  = byte_i;
        16'(TcpFlagsOff): cap_o.flags = byte_i[4:0];
        default: ;
      endcase
    end

    frame_d = cap_o;
    if (frame_q.offset != 16'hFFFF) begin
      frame_d.offset = frame_q.offset + 16'd1;
    end
    if (last_i) begin
      frame_d = FrameReset;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= FrameReset;
    end else if (step_i) begin
      frame_q <= frame_d;
    end
  end

endmodule

// ----- hw/rtl/eitp_classify.sv -----
module eitp_classify import eitp_pkg::*; (
  input  frame_t   cap_i,
  output summary_t sum_o
);

  logic [6:0] tcp_last_off;
  logic       short_eth, short_ip, bad_ihl, short_tcp;

  // length compares done on the offset of the last byte (length - 1)
  assign tcp_last_off = 7'(EthHdrLen + TcpMinLen - 1) + {1'b0, cap_i.header_words, 2'b00};
  assign short_eth = cap_i.offset < 16'(EthHdrLen - 1);
  assign short_ip  = cap_i.offset < 16'(EthHdrLen + IpMinLen - 1);
  assign bad_ihl   = {cap_i.header_words, 2'b00} < 6'(IpMinLen);
  assign short_tcp = cap_i.offset < {9'd0, tcp_last_off};

  always_comb begin
    sum_o = '{
      status:         ST_OK,
      packet_type:    PKT_UNKNOWN,
      transport_type: TR_UNKNOWN,
      total_length:   16'd0,
      source_address: 32'd0,
      dest_address:   32'd0,
      source_port:    16'hFFFF,
      dest_port:      16'hFFFF,
      tcp_flag_bits:  5'd0
    };
    if (short_eth) begin
      sum_o.status = ST_SHORT_ETH;
    end else if (cap_i.ether_kind == EtherTypeIpv4) begin
      if (short_ip) begin
        sum_o.status = ST_SHORT_IP;
      end else if (bad_ihl) begin
        sum_o.status = ST_BAD_IHL;
      end else begin
        sum_o.packet_type    = PKT_IPV4;
        sum_o.total_length   = cap_i.length;
        sum_o.source_address = cap_i.src_addr;
        sum_o.dest_address   = cap_i.dst_addr;
        if (cap_i.proto == ProtoTcp) begin
          if (short_tcp) begin
            sum_o.status = ST_SHORT_TCP;
          end else begin
            sum_o.transport_type = TR_TCP;
            sum_o.source_port    = cap_i.src_port;
            sum_o.dest_port      = cap_i.dst_port;
            sum_o.tcp_flag_bits  = cap_i.flags;
          end
        end else if (cap_i.proto == ProtoUdp) begin
          sum_o.transport_type = TR_UDP;
        end else if (cap_i.proto == ProtoIcmp) begin
          sum_o.transport_type = TR_ICMP;
        end
      end
    end else if (cap_i.ether_kind == EtherTypeArp) begin
      sum_o.packet_type = PKT_ARP;
    end
  end

endmodule

// ----- hw/rtl/eitp_checker.sv -----
`include "eth_ipv4_tcp_header_parser_unit_defines.svh"

module eitp_checker import eitp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  data_byte_i,
  input logic        last_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  status_o,
  input logic [1:0]  packet_type_o,
  input logic [1:0]  transport_type_o,
  input logic [15:0] total_length_o,
  input logic [31:0] source_address_o,
  input logic [31:0] dest_address_o,
  input logic [15:0] source_port_o,
  input logic [15:0] dest_port_o,
  input logic [4:0]  tcp_flag_bits_o
);

  logic unused_in;
  assign unused_in = in_valid_i ^ in_stall_o ^ last_i ^ (^data_byte_i);

  // a held summary stays put
  `EITP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(status_o) && $stable(source_address_o) && $stable(source_port_o))

  // early failures report no packet type and no ip fields
  `EITP_ASSERT_NOW(a_fail_blank, clk_i, rst_ni,
    out_valid_o && (status_o == ST_SHORT_ETH || status_o == ST_SHORT_IP ||
                    status_o == ST_BAD_IHL),
    packet_type_o == PKT_UNKNOWN && total_length_o == 16'd0 && source_address_o == 32'd0)

  // short tcp keeps the ip fields but not the transport
  `EITP_ASSERT_NOW(a_short_tcp, clk_i, rst_ni, out_valid_o && status_o == ST_SHORT_TCP,
    packet_type_o == PKT_IPV4 && transport_type_o == TR_UNKNOWN)

  // ports and flags only come with a complete tcp frame
  `EITP_ASSERT_NOW(a_tcp_fields, clk_i, rst_ni, out_valid_o && transport_type_o != TR_TCP,
    source_port_o == 16'hFFFF && dest_port_o == 16'hFFFF && tcp_flag_bits_o == 5'd0)

  // a transport is reported only on an ipv4 frame
  `EITP_ASSERT_NOW(a_trans_ipv4, clk_i, rst_ni, out_valid_o && transport_type_o != TR_UNKNOWN,
    packet_type_o == PKT_IPV4 && status_o == ST_OK)

endmodule

bind eth_ipv4_tcp_header_parser_unit eitp_checker u_eitp_checker (.*);

// ----- tb/sv/eitp_summary_check.sv -----
module eitp_summary_check
  import eitp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  status_i,
  input  logic [1:0]  packet_type_i,
  input  logic [1:0]  transport_type_i,
  input  logic [15:0] total_length_i,
  input  logic [31:0] source_address_i,
  input  logic [31:0] dest_address_i,
  input  logic [15:0] source_port_i,
  input  logic [15:0] dest_port_i,
  input  logic [4:0]  tcp_flag_bits_i,
  output int          mismatch_count_o,
  output int          pending_count_o,
  output int          summary_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  frame_t   frame_model;
  summary_t expected_summaries[$];
  summary_t oldest_summary;

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      mismatch_count_o++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  // advance the decode state by one frame byte, queue a summary on the last one
  task automatic absorb_byte(input logic [7:0] b, input logic fin);
    int       off;
    int       tcp_start;
    int       frame_len;
    summary_t s;
    off = frame_model.offset;
    case (off)
      12: frame_model.ether_kind[15:8] = b;
      13: frame_model.ether_kind[7:0] = b;
      14: frame_model.header_words = b[3:0];
      16: frame_model.length[15:8] = b;
      17: frame_model.length[7:0] = b;
      23: frame_model.proto = b;
      default: begin
        if (off >= 26 && off <= 29) frame_model.src_addr = {frame_model.src_addr[23:0], b};
        if (off >= 30 && off <= 33) frame_model.dst_addr = {frame_model.dst_addr[23:0], b};
      end
    endcase
    // tcp header sits right after the ip options
    if (int'(frame_model.header_words) * WordBytes >= IpMinLen) begin
      tcp_start = EthHdrLen + WordBytes * int'(frame_model.header_words);
      if (off >= tcp_start) begin
        case (off - tcp_start)
          0: frame_model.src_port[15:8] = b;
          1: frame_model.src_port[7:0] = b;
          2: frame_model.dst_port[15:8] = b;
          3: frame_model.dst_port[7:0] = b;
          TcpFlagsOff: frame_model.flags = b[4:0];
          default: ;
        endcase
      end
    end
    if (frame_model.offset != 16'hFFFF) frame_model.offset++;
    if (fin) begin
      frame_len = off + 1;
      s = '0;
      s.source_port = 16'hFFFF;
      s.dest_port = 16'hFFFF;
      if (frame_len < EthHdrLen) begin
        s.status = ST_SHORT_ETH;
      end else if (frame_model.ether_kind == EtherTypeIpv4) begin
        if (frame_len < EthHdrLen + IpMinLen) begin
          s.status = ST_SHORT_IP;
        end else if (int'(frame_model.header_words) * WordBytes < IpMinLen) begin
          s.status = ST_BAD_IHL;
        end else begin
          s.packet_type = PKT_IPV4;
          s.total_length = frame_model.length;
          s.source_address = frame_model.src_addr;
          s.dest_address = frame_model.dst_addr;
          if (frame_model.proto == ProtoTcp) begin
            if (frame_len < EthHdrLen + WordBytes * int'(frame_model.header_words)
                + TcpMinLen) begin
              s.status = ST_SHORT_TCP;
            end else begin
              s.transport_type = TR_TCP;
              s.source_port = frame_model.src_port;
              s.dest_port = frame_model.dst_port;
              s.tcp_flag_bits = frame_model.flags;
            end
          end else if (frame_model.proto == ProtoUdp) begin
            s.transport_type = TR_UDP;
          end else if (frame_model.proto == ProtoIcmp) begin
            s.transport_type = TR_ICMP;
          end
        end
      end else if (frame_model.ether_kind == EtherTypeArp) begin
        s.packet_type = PKT_ARP;
      end
      expected_summaries.push_back(s);
      frame_model = FrameReset;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_model = FrameReset;
      expected_summaries.delete();
      mismatch_count_o = 0;
      pending_count_o = 0;
      summary_count_o = 0;
    end else begin
      // a summary can never belong to a byte taken at the same edge
      if (out_valid_i && !out_stall_i) begin
        if (expected_summaries.size() == 0) begin
          mismatch_count_o++;
          $display("%0t: summary expected none actual status %0h type %0h", $time,
                   status_i, packet_type_i);
        end else begin
          oldest_summary = expected_summaries.pop_front();
          summary_count_o++;
          compare_field("status", 32'(oldest_summary.status), 32'(status_i));
          compare_field("packet_type", 32'(oldest_summary.packet_type), 32'(packet_type_i));
          compare_field("transport_type", 32'(oldest_summary.transport_type),
                        32'(transport_type_i));
          compare_field("total_length", 32'(oldest_summary.total_length),
                        32'(total_length_i));
          compare_field("source_address", oldest_summary.source_address, source_address_i);
          compare_field("dest_address", oldest_summary.dest_address, dest_address_i);
          compare_field("source_port", 32'(oldest_summary.source_port), 32'(source_port_i));
          compare_field("dest_port", 32'(oldest_summary.dest_port), 32'(dest_port_i));
          compare_field("tcp_flag_bits", 32'(oldest_summary.tcp_flag_bits),
                        32'(tcp_flag_bits_i));
        end
      end
      if (in_valid_i && !in_stall_i) absorb_byte(data_byte_i, last_i);
      pending_count_o = expected_summaries.size();
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
  import eitp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // byte fill patterns for built frames
  localparam int FillRandom = 0;
  localparam int FillZeros  = 1;
  localparam int FillOnes   = 2;

  localparam int CycleLimit   = 1000000;
  localparam int DrainCycles  = 10;
  localparam int PhaseBytes   = 90;
  localparam int PhaseFrames  = 2;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        last;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  status;
  logic [1:0]  packet_type;
  logic [1:0]  transport_type;
  logic [15:0] total_length;
  logic [31:0] source_address;
  logic [31:0] dest_address;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [4:0]  tcp_flag_bits;

  int mismatch_count;
  int pending_count;
  int summary_count;

  int idle_pct;
  int stall_pct;
  int cycle_count;
  int bytes_sent;
  int frames_sent;

  logic [7:0] frame_bytes[$];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  eth_ipv4_tcp_header_parser_unit uut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .data_byte_i      (data_byte),
    .last_i           (last),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .status_o         (status),
    .packet_type_o    (packet_type),
    .transport_type_o (transport_type),
    .total_length_o   (total_length),
    .source_address_o (source_address),
    .dest_address_o   (dest_address),
    .source_port_o    (source_port),
    .dest_port_o      (dest_port),
    .tcp_flag_bits_o  (tcp_flag_bits)
  );

  eitp_summary_check summary_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .data_byte_i      (data_byte),
    .last_i           (last),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .status_i         (status),
    .packet_type_i    (packet_type),
    .transport_type_i (transport_type),
    .total_length_i   (total_length),
    .source_address_i (source_address),
    .dest_address_i   (dest_address),
    .source_port_i    (source_port),
    .dest_port_i      (dest_port),
    .tcp_flag_bits_i  (tcp_flag_bits),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count),
    .summary_count_o  (summary_count)
  );

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d summaries outstanding", cycle_count,
               pending_count);
      $display("testbench NOT OK");
      $finish;
    end
  end

  // one word on the input channel, with a random idle gap in front
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    last <= fin;
    // payload holds until the word is taken
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_frame(ref logic [7:0] f[$]);
    for (int i = 0; i < f.size(); i++) send_byte(f[i], i == f.size() - 1);
    frames_sent++;
  endtask

  // frame of given length; only the ethertype, ihl and protocol bytes are placed,
  // everything else comes from the fill pattern
  task automatic make_frame(ref logic [7:0] f[$], input logic [15:0] etype,
                            input logic [3:0] ihl, input logic [7:0] proto,
                            input int len, input int fill);
    logic [3:0] version;
    f.delete();
    for (int i = 0; i < len; i++) begin
      case (fill)
        FillZeros: f.push_back(8'h00);
        FillOnes:  f.push_back(8'hFF);
        default:   f.push_back(8'($urandom));
      endcase
    end
    // version nibble is not looked at, so vary it now and then
    case (fill)
      FillZeros: version = 4'h0;
      FillOnes:  version = 4'hF;
      default:   version = ($urandom_range(3) == 0) ? 4'($urandom) : 4'h4;
    endcase
    if (len > 12) f[12] = etype[15:8];
    if (len > 13) f[13] = etype[7:0];
    if (len > 14) f[14] = {version, ihl};
    if (len > 23) f[23] = proto;
  endtask

  task automatic directed_frame(input logic [15:0] etype, input logic [3:0] ihl,
                                input logic [7:0] proto, input int len, input int fill);
    make_frame(frame_bytes, etype, ihl, proto, len, fill);
    send_frame(frame_bytes);
  endtask

  function automatic logic [7:0] other_proto();
    case ($urandom_range(2))
      0:       return ProtoUdp;
      1:       return ProtoIcmp;
      default: return 8'($urandom);
    endcase
  endfunction

  // mostly well-formed tcp frames, the rest other protocols, truncations and noise
  task automatic build_random_frame(ref logic [7:0] f[$]);
    int          pick;
    int          ihl;
    int          tail;
    int          len;
    logic [15:0] etype;
    logic [7:0]  proto;
    pick = $urandom_range(99);
    ihl = ($urandom_range(3) == 0) ? $urandom_range(15, 5) : 5;
    tail = ($urandom_range(4) == 0) ? $urandom_range(40) : $urandom_range(6);
    etype = EtherTypeIpv4;
    proto = ProtoTcp;
    if (pick < 55) begin
      len = EthHdrLen + WordBytes * ihl + TcpMinLen + tail;
    end else if (pick < 63) begin
      proto = other_proto();
      len = EthHdrLen + WordBytes * ihl + tail;
    end else if (pick < 68) begin
      etype = EtherTypeArp;
      len = $urandom_range(64, EthHdrLen);
    end else if (pick < 73) begin
      etype = 16'($urandom);
      len = $urandom_range(70, EthHdrLen);
    end else if (pick < 78) begin
      // too short for an ethernet header
      len = $urandom_range(EthHdrLen - 1, 1);
    end else if (pick < 84) begin
      // ethernet header but no full ip header
      len = $urandom_range(EthHdrLen + IpMinLen - 1, EthHdrLen);
    end else if (pick < 90) begin
      ihl = $urandom_range(4, 0);
      len = $urandom_range(70, EthHdrLen + IpMinLen);
    end else if (pick < 96) begin
      // tcp header cut off somewhere
      len = $urandom_range(EthHdrLen + WordBytes * ihl + TcpMinLen - 1,
                           EthHdrLen + IpMinLen);
    end else begin
      case ($urandom_range(2))
        0:       etype = EtherTypeIpv4;
        1:       etype = EtherTypeArp;
        default: etype = 16'($urandom);
      endcase
      ihl = $urandom_range(15);
      proto = $urandom_range(1) ? ProtoTcp : other_proto();
      len = $urandom_range(100, 1);
    end
    make_frame(f, etype, 4'(ihl), proto, len, FillRandom);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    data_byte = 8'h00;
    last = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    bytes_sent = 0;
    frames_sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames, no idling
    directed_frame(EtherTypeIpv4, 4'd5, ProtoTcp, 1, FillRandom);
    directed_frame(EtherTypeIpv4, 4'd5, ProtoTcp, EthHdrLen - 1, FillOnes);
    directed_frame(EtherTypeIpv4, 4'd5, ProtoTcp, EthHdrLen, FillRandom);
    directed_frame(EtherTypeIpv4, 4'd5, ProtoTcp, EthHdrLen + IpMinLen - 1, FillOnes);
    directed_frame(EtherTypeIpv4, 4'd0, ProtoTcp, EthHdrLen + IpMinLen, FillZeros);
    directed_frame(EtherTypeIpv4, 4'd4, ProtoTcp, 60, FillRandom);
    directed_frame(EtherTypeIpv4, 4'd5, ProtoTcp, EthHdrLen + IpMinLen, FillRandom);
    directed_frame(EtherTypeIpv4, 4'd5, ProtoUdp, EthHdrLen + IpMinLen, FillOnes);
    directed_frame(EtherTypeIpv4, 4'd5, ProtoIcmp, EthHdrLen + IpMinLen, FillZeros);
    directed_frame(EtherTypeIpv4, 4'd5, 8'hFF, 40, FillRandom);
    directed_frame(EtherTypeIpv4, 4'd5, ProtoTcp, 53, FillRandom);
    directed_frame(EtherTypeIpv4, 4'd5, ProtoTcp, 54, FillZeros);
    directed_frame(EtherTypeIpv4, 4'd5, ProtoTcp, 54, FillOnes);
    directed_frame(EtherTypeIpv4, 4'd15, ProtoTcp, 87, FillRandom);
    directed_frame(EtherTypeIpv4, 4'd15, ProtoTcp, 88, FillOnes);
    directed_frame(EtherTypeIpv4, 4'd15, ProtoUdp, 90, FillRandom);
    directed_frame(EtherTypeArp, 4'd5, ProtoTcp, EthHdrLen, FillRandom);
    directed_frame(EtherTypeArp, 4'd5, ProtoTcp, 60, FillOnes);
    directed_frame(16'h0000, 4'd5, ProtoTcp, 60, FillZeros);
    directed_frame(16'hFFFF, 4'd5, ProtoTcp, 60, FillOnes);
    directed_frame(16'h0801, 4'd5, ProtoTcp, 60, FillRandom);

    // random frames in four idling phases
    for (int phase = 0; phase < 4; phase++) begin
      int phase_start_bytes;
      int phase_start_frames;
      case (phase)
        0:       begin idle_pct = 0;  stall_pct <= 0;  end
        1:       begin idle_pct = 66; stall_pct <= 0;  end
        2:       begin idle_pct = 0;  stall_pct <= 66; end
        default: begin idle_pct = 13; stall_pct <= 13; end
      endcase
      phase_start_bytes = bytes_sent;
      phase_start_frames = frames_sent;
      while (bytes_sent - phase_start_bytes < PhaseBytes
             || frames_sent - phase_start_frames < PhaseFrames) begin
        build_random_frame(frame_bytes);
        send_frame(frame_bytes);
      end
    end
    in_valid <= 1'b0;

    // let the checker see the last word, then drain the summaries
    @(posedge clk);
    wait (pending_count == 0);
    repeat (DrainCycles) @(posedge clk);

    $display("sent %0d frames (%0d bytes) incl. boundary lengths, checked %0d summaries",
             frames_sent, bytes_sent, summary_count);
    $display("idling phases: none, sender 66%%, receiver 66%%, both 13%%; %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/eitp_pkg.sv
hw/rtl/eitp_capture.sv
hw/rtl/eitp_classify.sv
hw/rtl/eth_ipv4_tcp_header_parser_unit.sv
hw/rtl/eitp_checker.sv
tb/sv/eitp_summary_check.sv
tb/sv/testbench.sv
